// ===== design/assert_macros.svh =====
// Assertion macros for the LRU page replacement core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define LPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define LPR_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define LPR_ASSERT(lbl, prop, msg)
`define LPR_NEVER(lbl, prop, msg)
`endif

`endif

// ===== design/lpr_pkg.sv =====
// Shared constants for the LRU page replacement core.
package lpr_pkg;

  localparam int unsigned PAGE_W        = 16;  // page field width on the ports
  localparam int unsigned CNT_W         = 32;  // replacement counter width
  localparam int unsigned CFG_W         = 5;   // frame limit register width
  localparam int unsigned FRAMES_DEF    = 16;
  localparam int unsigned PAGE_BITS_DEF = 16;
  localparam logic [CFG_W-1:0] LIMIT_RST = CFG_W'(16);

endpackage

// ===== design/lpr_if.sv =====
// Valid/ready channels for page references and replacement results.
interface lpr_page_if;
  import lpr_pkg::*;

  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

interface lpr_result_if;
  import lpr_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic              evicted;
  logic [PAGE_W-1:0] evicted_page;
  logic [CNT_W-1:0]  replacement_count;

  modport source (output valid, output hit, output evicted, output evicted_page,
                  output replacement_count, input ready);
  modport sink   (input valid, input hit, input evicted, input evicted_page,
                  input replacement_count, output ready);
endinterface

// ===== design/lpr_cell.sv =====
// One recency stack cell: holds a page, compares it, shifts down on removal.
module lpr_cell #(
  parameter int unsigned EW  = 16,
  parameter int unsigned OW  = 5,
  parameter int unsigned IDX = 0
) (
  input  logic          clk_i,
  input  logic          en_i,     // reference transfer this cycle
  input  logic [OW-1:0] occ_i,    // resident page count
  input  logic [OW-1:0] top_i,    // slot that receives the new page
  input  logic [EW-1:0] pg_i,
  input  logic [EW-1:0] up_i,     // neighbor above (more recent)
  input  logic          kill_i,   // removal point is below this cell
  output logic          kill_o,
  output logic          match_o,
  output logic [EW-1:0] data_o
);

  localparam logic [OW-1:0] MY_IDX = OW'(IDX);

  logic [EW-1:0] data_q;
  logic [EW-1:0] data_d;

  assign match_o = (MY_IDX < occ_i) && (data_q == pg_i);
  assign kill_o  = kill_i | match_o;
  assign data_o  = data_q;

  always_comb begin
    data_d = data_q;
    if (MY_IDX == top_i) begin
      data_d = pg_i;
    end else if (kill_o && (MY_IDX < top_i)) begin
      data_d = up_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== design/lru_page_replacement_core.sv =====
// LRU page replacement core: recency stack built as a chain of compare/shift cells.
// Output: a result is registered and shows in the cycle after its reference transfer.
// Throughput: one reference per cycle while the receiver takes results; all cells
// compare in parallel and shift in the same cycle, so the compare plus removal-point chain across FRAMES cells sets it.
// Reset: occupancy and replacement count clear, frame limit returns to 16,
// stack contents are left as they are (only slots below occupancy are ever read).
`include "assert_macros.svh"

module lru_page_replacement_core #(
  parameter int unsigned FRAMES    = lpr_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [lpr_pkg::CFG_W-1:0] cfg_wdata_i,
  lpr_page_if.sink                 page_i,
  lpr_result_if.source             result_o
);
  import lpr_pkg::*;

  // stored page width: the narrower of PAGE_BITS and the port width; higher page bits are ignored and read back as zero
  localparam int unsigned EW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int unsigned OW = $clog2(FRAMES + 1);
  localparam int unsigned LW = (OW > CFG_W) ? OW : CFG_W;

  // configuration and bookkeeping
  logic [CFG_W-1:0] limit_q;
  logic [OW-1:0]    occ_q, occ_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // output register
  logic              out_valid_q;
  logic              hit_q, evicted_q;
  logic [PAGE_W-1:0] evp_q;

  // cell chain
  logic [FRAMES-1:0] match;
  logic [FRAMES-1:0] kill;
  logic [EW-1:0]     ent [FRAMES];
  logic [EW-1:0]     pg;
  logic [LW-1:0]     lim;
  logic              xfer, hit, evict;
  logic [OW-1:0]     top;

  assign pg = page_i.page[EW-1:0];

  // limit of zero acts as one, above FRAMES acts as FRAMES
  always_comb begin
    if (limit_q == '0) begin
      lim = LW'(1);
    end else if (LW'(limit_q) > LW'(FRAMES)) begin
      lim = LW'(FRAMES);
    end else begin
      lim = LW'(limit_q);
    end
  end

  // a slot frees only while the output register can take the result
  assign page_i.ready = !out_valid_q || result_o.ready;
  assign xfer         = page_i.valid && page_i.ready;

  assign hit   = |match;
  assign evict = !hit && (LW'(occ_q) >= lim);
  // hit or evict removes one entry before the new page goes on top
  assign top   = (hit || evict) ? occ_q - OW'(1) : occ_q;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    logic [EW-1:0] up;
    logic          kin;
    if (i == FRAMES - 1) begin : g_last
      assign up = pg;  // never selected: top slot takes pg directly
    end else begin : g_mid
      assign up = ent[i+1];
    end
    if (i == 0) begin : g_first
      assign kin = evict;  // eviction removes the least recent slot
    end else begin : g_rest
      assign kin = kill[i-1];
    end
    lpr_cell #(
      .EW  (EW),
      .OW  (OW),
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .en_i    (xfer),
      .occ_i   (occ_q),
      .top_i   (top),
      .pg_i    (pg),
      .up_i    (up),
      .kill_i  (kin),
      .kill_o  (kill[i]),
      .match_o (match[i]),
      .data_o  (ent[i])
    );
  end

  always_comb begin
    occ_d = occ_q;
    cnt_d = cnt_q;
    if (!hit && !evict) begin
      occ_d = occ_q + OW'(1);
    end
    if (evict && (cnt_q != '1)) begin
      cnt_d = cnt_q + CNT_W'(1);  // saturates at all ones
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RST;
      occ_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (xfer) begin
        occ_q       <= occ_d;
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      hit_q     <= hit;
      evicted_q <= evict;
      evp_q     <= evict ? PAGE_W'(ent[0]) : '0;
    end
  end

  // count register only moves on a transfer, so it holds with the result
  assign result_o.valid             = out_valid_q;
  assign result_o.hit               = hit_q;
  assign result_o.evicted           = evicted_q;
  assign result_o.evicted_page      = evp_q;
  assign result_o.replacement_count = cnt_q;

  `LPR_NEVER(a_occ_bound, occ_q > OW'(FRAMES), "occupancy above frame count")
  `LPR_NEVER(a_hit_evict, out_valid_q && hit_q && evicted_q, "hit result also evicts")
  `LPR_ASSERT(a_evict_occ, (xfer && evict) |=> $stable(occ_q), "eviction changed occupancy")
  `LPR_ASSERT(a_fill_occ, (xfer && !hit && !evict) |=> (occ_q == $past(occ_q) + OW'(1)),
              "fill did not grow occupancy")
  `LPR_ASSERT(a_cnt_step, xfer |=> ((cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CNT_W'(1))),
              "replacement count jumped")

endmodule

// ===== bench/tb_lru_page_replacement_core.sv =====
// Self-checking testbench for the LRU page replacement core.
`timescale 1ns / 100ps

module tb_lru_page_replacement_core;
  import lpr_pkg::*;

  localparam int unsigned FRAMES     = FRAMES_DEF;
  localparam int unsigned IDLE_LIMIT = 2000;  // cycles with no transfer before giving up
  localparam int unsigned CHOKE_LEN  = 240;   // long receiver hold-off, in cycles

  // One expected result per page reference.
  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic [PAGE_W-1:0] evicted_page;
    logic [CNT_W-1:0]  replacement_count;
  } lru_outcome_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  lpr_page_if   page_ch ();
  lpr_result_if res_ch ();

  lru_page_replacement_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .page_i     (page_ch),
    .result_o   (res_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: recency stack (entry 0 least recent), occupancy,
  // saturating replacement total and the frame limit register.
  // ---------------------------------------------------------------------------
  logic [PAGE_W-1:0] recency [FRAMES];
  int unsigned       resident = 0;
  logic [CNT_W-1:0]  replace_total = '0;
  logic [CFG_W-1:0]  limit_reg = LIMIT_RST;

  // Limit as the block applies it: zero acts as one, above FRAMES acts as FRAMES.
  function automatic int unsigned frames_in_use(input logic [CFG_W-1:0] lim);
    if (lim == 0) return 1;
    if (lim > FRAMES) return FRAMES;
    return lim;
  endfunction

  // Apply one page reference to the shadow and return the result it gives.
  function automatic lru_outcome_t lru_reference(input logic [PAGE_W-1:0] pg);
    lru_outcome_t r;
    int           pos;
    r   = '0;
    pos = -1;
    for (int i = 0; i < resident; i++)
      if (pos < 0 && recency[i] == pg) pos = i;
    if (pos >= 0) begin
      // hit: pull the page out, it goes back on top below
      r.hit = 1'b1;
      for (int i = pos; i + 1 < resident; i++) recency[i] = recency[i + 1];
      resident--;
    end else if (resident >= frames_in_use(limit_reg) && resident > 0) begin
      // miss with no room (also when the limit dropped under occupancy):
      // only the least recent page goes
      r.evicted      = 1'b1;
      r.evicted_page = recency[0];
      for (int i = 0; i + 1 < resident; i++) recency[i] = recency[i + 1];
      resident--;
      if (replace_total != '1) replace_total++;
    end
    if (resident < FRAMES) begin
      recency[resident] = pg;
      resident++;
    end
    r.replacement_count = replace_total;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues and counters
  // ---------------------------------------------------------------------------
  logic [PAGE_W-1:0] page_q [$];      // references waiting for the driver
  lru_outcome_t      outcome_q [$];   // results owed by the block, oldest first
  int unsigned       err_count = 0;
  int unsigned       ref_count = 0;
  int unsigned       result_count = 0;
  int unsigned       hit_count = 0;
  int unsigned       evict_count = 0;
  int unsigned       limit_writes = 0;
  int unsigned       choke_seq = 0;   // bumped by stimulus to request a long hold-off

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH result %0d: %s", $time, result_count, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Reference driver: bursts of random length, random gaps in between.
  // valid only drops after a transfer or while idle, never under a stall.
  // ---------------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_ch.valid <= 1'b0;
      page_ch.page  <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (page_ch.valid && page_ch.ready) begin
        outcome_q.push_back(lru_reference(page_ch.page));
        ref_count++;
      end
      if (!page_ch.valid || page_ch.ready) begin
        if (gap_left > 0 || page_q.size() == 0) begin
          page_ch.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          page_ch.valid <= 1'b1;
          page_ch.page  <= page_q.pop_front();
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            // a quarter of bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: ready follows a mode picked per window (always ready,
  // random, one in three). A choke request holds ready low for the CHOKE_LEN
  // hold-off so the result register fills and the block back-pressures.
  // ---------------------------------------------------------------------------
  int unsigned choke_seen;
  int unsigned hold_left;
  int unsigned win_left;
  int unsigned stall_mode;
  int unsigned phase_cnt;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      choke_seen = 0;
      hold_left  = 0;
      win_left   = 0;
      stall_mode = 0;
      phase_cnt  = 0;
    end else begin
      if (choke_seq != choke_seen) begin
        choke_seen = choke_seq;
        hold_left  = CHOKE_LEN;
      end
      if (win_left == 0) begin
        win_left   = $urandom_range(8, 64);
        stall_mode = $urandom_range(0, 2);
      end
      win_left--;
      phase_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= ($urandom_range(0, 9) < 7);
          default: res_ch.ready <= (phase_cnt % 3 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: every transfer is checked field by field against the
  // oldest outstanding outcome.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    lru_outcome_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result transfer with nothing outstanding");
      end else begin
        want = outcome_q.pop_front();
        if (res_ch.hit !== want.hit)
          report_mismatch($sformatf("hit %0b, want %0b", res_ch.hit, want.hit));
        if (res_ch.evicted !== want.evicted)
          report_mismatch($sformatf("evicted %0b, want %0b", res_ch.evicted, want.evicted));
        if (res_ch.evicted_page !== want.evicted_page)
          report_mismatch($sformatf("evicted_page %h, want %h",
                                    res_ch.evicted_page, want.evicted_page));
        if (res_ch.replacement_count !== want.replacement_count)
          report_mismatch($sformatf("replacement_count %0d, want %0d",
                                    res_ch.replacement_count, want.replacement_count));
        if (want.hit) hit_count++;
        if (want.evicted) evict_count++;
      end
      result_count++;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: cycles in a row with no transfer on either channel.
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((page_ch.valid && page_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Wait until the driver is empty and every outstanding result has arrived.
  // Each reference yields a result, so the block is idle then.
  task automatic settle();
    while (page_q.size() != 0 || page_ch.valid || outcome_q.size() != 0)
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    limit_reg = v;
    limit_writes++;
  endtask

  // Mostly references to a small working set a bit larger than the frame
  // count, so hits, fills and evictions all happen; the rest are random
  // pages, all-zero / all-one pages and single-bit pages.
  task automatic queue_phase(input int unsigned n_items);
    logic [PAGE_W-1:0] pool [$];
    int unsigned       pool_n;
    int unsigned       pick;
    pool_n = frames_in_use(limit_reg) + $urandom_range(1, frames_in_use(limit_reg) + 3);
    repeat (pool_n) pool.push_back(PAGE_W'($urandom));
    repeat (n_items) begin
      pick = $urandom_range(0, 19);
      if (pick < 16)
        page_q.push_back(pool[$urandom_range(0, pool_n - 1)]);
      else if (pick < 18)
        page_q.push_back(PAGE_W'($urandom));
      else if (pick == 18)
        page_q.push_back($urandom_range(0, 1) ? '1 : '0);
      else
        page_q.push_back(PAGE_W'(1) << $urandom_range(0, PAGE_W - 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] phase_limits [11] = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd8,
                                          5'd20, 5'd3, 5'd12, 5'd16, 5'd2};

  initial begin
    page_ch.valid = 1'b0;
    page_ch.page  = '0;
    res_ch.ready  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme pages at the reset limit, a repeat for a hit.
    page_q.push_back('0);
    page_q.push_back('1);
    page_q.push_back('0);
    settle();

    // Limit zero acts as one frame; also starts below the current occupancy.
    write_limit(5'd0);
    page_q.push_back(16'h1234);
    page_q.push_back(16'h1234);
    page_q.push_back('1);
    settle();

    // Limit above FRAMES: fill every frame, then the remaining pages force evictions.
    write_limit(5'd31);
    for (int k = 1; k <= 17; k++) page_q.push_back(16'h0100 + PAGE_W'(k));
    settle();

    // Limit lowered under a full stack: a miss replaces one page only,
    // a hit only reorders.
    write_limit(5'd2);
    page_q.push_back(16'h0200);
    page_q.push_back(16'h0111);
    settle();

    // Random phases; each limit change happens with the block drained.
    foreach (phase_limits[p]) begin
      if (p == 6 || p == 8)
        write_limit(CFG_W'($urandom_range(1, FRAMES)));
      else
        write_limit(phase_limits[p]);
      // one phase starts with the receiver choked while references keep coming
      if (p == 2) choke_seq++;
      queue_phase(150);
      settle();
    end

    repeat (4) @(posedge clk_i);
    $display("Ran %0d page references over %0d frame limit settings.", ref_count, limit_writes);
    $display("Saw %0d hits and %0d evictions across %0d results.",
             hit_count, evict_count, result_count);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", err_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
